// File: hdl/bqcr_pkg.sv
// ----------------------------------------------------------------------------
// Biquad coefficient ramp package
// Shared constants: default and fixed widths, transaction actions, register indexes and coefficient slots.
// ----------------------------------------------------------------------------
package bqcr_pkg;

  // Default widths of the datapath.
  localparam int DEF_SAMPLE_WIDTH   = 24;
  localparam int DEF_HISTORY_WIDTH  = 32;
  localparam int DEF_COEF_FRAC_BITS = 20;

  // Fixed widths of the configuration port, the action field, the ramp count and the coefficient fields.
  localparam int CFG_DATA_WIDTH  = 60;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int ACTION_WIDTH    = 2;
  localparam int RAMP_WIDTH      = 12;
  localparam int FIELD_WIDTH     = 20;

  // Actions carried by an input transaction.
  localparam logic [ACTION_WIDTH-1:0] ACT_FILTER = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_LOAD   = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_START = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FB_START = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_STEP  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FB_STEP  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMP     = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE   = 3'd6;

  // Coefficient slots, in the packing order of the registers.
  localparam int CO_B0 = 0;
  localparam int CO_B1 = 1;
  localparam int CO_B2 = 2;
  localparam int CO_A1 = 3;
  localparam int CO_A2 = 4;
  localparam int NUM_COEF = 5;

endpackage

// File: hdl/biquad_filter_coefficient_ramp_unit.sv
// ----------------------------------------------------------------------------
// Biquad filter with coefficient ramp
// Direct form II biquad for one voice, with a linear coefficient ramp and
// optional history compensation, built around one bit-serial multiplier
// and one bit-serial divider.
// ----------------------------------------------------------------------------
// A filtered sample runs five products in turn (a1, a2, b1, b2, b0), each
// through the load, multiply and accumulate states; while ramping, a ramp
// step and a compensation check follow, and with compensation a ratio
// division and two history products. Disabled samples go straight to done;
// load and clear finish in idle. One transaction is worked on at a time; the
// multiplier iterates one operand bit per cycle and sets the rate. Reset is
// synchronous and clears the configuration, coefficients, history and ramp.
module biquad_filter_coefficient_ramp_unit
  import bqcr_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int HISTORY_WIDTH  = DEF_HISTORY_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ACTION_WIDTH-1:0]           action,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
  output logic                              ramp_active,
  input  logic                              cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_data
);

  // Derived widths. CW is the coefficient width (Q4.F). QW bounds the
  // compensation ratio, which is below 1000 * 2^(CW-1). PW is the full
  // product width, RW the product after rounding away the fraction, and
  // AW the accumulator. NW is the dividend width of the ratio division.
  localparam int SW   = SAMPLE_WIDTH;
  localparam int HW   = HISTORY_WIDTH;
  localparam int F    = COEF_FRAC_BITS;
  localparam int CW   = F + 4;
  localparam int QW   = CW + 10;
  localparam int PW   = QW + HW;
  localparam int RW   = PW - F;
  localparam int AW   = RW + 3;
  localparam int NW   = CW + F;
  localparam int CNTW = $clog2(NW + 1);

  // Requantisation shifts: start values Q4.16, increments Q1.19.
  localparam int LS_START = (F >= 16) ? F - 16 : 0;
  localparam int RS_START = (F >= 16) ? 0 : 16 - F;
  localparam int LS_STEP  = (F >= 19) ? F - 19 : 0;
  localparam int RS_STEP  = (F >= 19) ? 0 : 19 - F;
  localparam int XW       = CW + FIELD_WIDTH;

  localparam logic [PW:0]    ROUND_HALF = (PW + 1)'(1) << (F - 1);
  localparam logic [CW+9:0]  THRESHOLD  = (CW + 10)'(1) << F;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_RAMP  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Products, in the order the sequencer runs them.
  localparam logic [2:0] OP_A1 = 3'd0;
  localparam logic [2:0] OP_A2 = 3'd1;
  localparam logic [2:0] OP_B1 = 3'd2;
  localparam logic [2:0] OP_B2 = 3'd3;
  localparam logic [2:0] OP_B0 = 3'd4;
  localparam logic [2:0] OP_R1 = 3'd5;
  localparam logic [2:0] OP_R2 = 3'd6;

  // Configuration registers.
  logic [3*FIELD_WIDTH-1:0] ff_start;
  logic [2*FIELD_WIDTH-1:0] fb_start;
  logic [3*FIELD_WIDTH-1:0] ff_step;
  logic [2*FIELD_WIDTH-1:0] fb_step;
  logic [RAMP_WIDTH-1:0]    ramp_samples;
  logic                     compensate_enable;
  logic                     filter_enable;

  // Filter state.
  logic signed [CW-1:0]     coef [NUM_COEF];
  logic signed [CW-1:0]     inc [NUM_COEF];
  logic signed [HW-1:0]     delay_near;
  logic signed [HW-1:0]     delay_far;
  logic [RAMP_WIDTH-1:0]    ramp_left;

  // Sequencer and datapath registers.
  logic [2:0]               state;
  logic [2:0]               op;
  logic [CNTW-1:0]          cnt;
  logic [HW-1:0]            mul_hi;
  logic [QW-1:0]            mul_lo;
  logic [HW-1:0]            mul_cand;
  logic                     mul_neg;
  logic signed [AW-1:0]     acc;
  logic signed [HW-1:0]     w_reg;
  logic signed [SW-1:0]     y_reg;
  logic signed [CW-1:0]     old_b0;
  logic [NW-1:0]            div_num;
  logic [CW:0]              div_rem;
  logic [CW-1:0]            div_mag;

  logic                     in_accept;
  logic                     out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Start values and increments unpacked and moved to Q4.F. A right shift
  // of the sign-extended field gives the floor rounding required.
  logic [5*FIELD_WIDTH-1:0] start_all;
  logic [5*FIELD_WIDTH-1:0] step_all;
  logic signed [CW-1:0]     start_q [NUM_COEF];
  logic signed [CW-1:0]     step_q [NUM_COEF];
  logic signed [XW-1:0]     start_x [NUM_COEF];
  logic signed [XW-1:0]     step_x [NUM_COEF];

  assign start_all = {fb_start, ff_start};
  assign step_all  = {fb_step, ff_step};

  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      start_x[k] = (XW'($signed(start_all[k*FIELD_WIDTH +: FIELD_WIDTH])) <<< LS_START)
                   >>> RS_START;
      step_x[k]  = (XW'($signed(step_all[k*FIELD_WIDTH +: FIELD_WIDTH])) <<< LS_STEP)
                   >>> RS_STEP;
      start_q[k] = start_x[k][CW-1:0];
      step_q[k]  = step_x[k][CW-1:0];
    end
  end

  // Ramped coefficients, saturated to CW signed bits.
  logic signed [CW:0]       ramp_sum [NUM_COEF];
  logic signed [CW-1:0]     ramp_sat [NUM_COEF];

  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      ramp_sum[k] = {coef[k][CW-1], coef[k]} + {inc[k][CW-1], inc[k]};
      if (ramp_sum[k][CW] != ramp_sum[k][CW-1]) begin
        ramp_sat[k] = {ramp_sum[k][CW], {(CW-1){~ramp_sum[k][CW]}}};
      end else begin
        ramp_sat[k] = ramp_sum[k][CW-1:0];
      end
    end
  end

  // Operand selection for the multiplier. The multiplier operand is the
  // coefficient magnitude or the ratio; the multiplicand is the magnitude of a
  // history value or of w. Sign is carried apart, so rounding is symmetric about zero.
  logic signed [CW-1:0]     sel_coef;
  logic signed [HW-1:0]     sel_hist;
  logic                     sel_ratio;
  logic [CW-1:0]            sel_coef_mag;
  logic [HW-1:0]            sel_hist_mag;
  logic [QW-1:0]            sel_mult;
  logic                     sel_neg;
  logic                     ratio_neg;

  assign ratio_neg = old_b0[CW-1] ^ coef[CO_B0][CW-1];

  always_comb begin
    sel_ratio = 1'b0;
    case (op)
      OP_A1: begin
        sel_coef = coef[CO_A1];
        sel_hist = delay_near;
      end
      OP_A2: begin
        sel_coef = coef[CO_A2];
        sel_hist = delay_far;
      end
      OP_B1: begin
        sel_coef = coef[CO_B1];
        sel_hist = delay_near;
      end
      OP_B2: begin
        sel_coef = coef[CO_B2];
        sel_hist = delay_far;
      end
      OP_B0: begin
        sel_coef = coef[CO_B0];
        sel_hist = w_reg;
      end
      OP_R1: begin
        sel_coef  = coef[CO_B0];
        sel_hist  = delay_near;
        sel_ratio = 1'b1;
      end
      OP_R2: begin
        sel_coef  = coef[CO_B0];
        sel_hist  = delay_far;
        sel_ratio = 1'b1;
      end
      default: begin
        sel_coef = coef[CO_B0];
        sel_hist = delay_far;
      end
    endcase
    sel_coef_mag = sel_coef[CW-1] ? CW'(-sel_coef) : CW'(sel_coef);
    sel_hist_mag = sel_hist[HW-1] ? HW'(-sel_hist) : HW'(sel_hist);
    if (sel_ratio) begin
      sel_mult = div_num[QW-1:0];
      sel_neg  = ratio_neg ^ sel_hist[HW-1];
    end else begin
      sel_mult = QW'(sel_coef_mag);
      sel_neg  = sel_coef[CW-1] ^ sel_hist[HW-1];
    end
  end

  // One shift-and-add step: the multiplier bit at the bottom decides
  // whether the multiplicand is added into the upper half.
  logic [HW:0]              mul_sum;
  assign mul_sum = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, mul_cand} : '0);

  // Finished product. A coefficient product used only CW steps, so its
  // bits sit QW-CW places higher than those of a ratio product.
  logic [PW-1:0]            prod_full;
  logic [PW-1:0]            prod_mag;
  logic [PW:0]              prod_round;
  logic signed [RW+1:0]     prod_val;
  logic signed [AW-1:0]     prod_ext;

  assign prod_full  = {mul_hi, mul_lo};
  assign prod_mag   = (op >= OP_R1) ? prod_full : (prod_full >> (QW - CW));
  assign prod_round = {1'b0, prod_mag} + ROUND_HALF;
  assign prod_val   = mul_neg ? -$signed({1'b0, prod_round[PW:F]})
                              : $signed({1'b0, prod_round[PW:F]});
  assign prod_ext   = AW'(prod_val);

  logic signed [AW-1:0]     acc_sub;
  logic signed [AW-1:0]     acc_add;
  assign acc_sub = acc - prod_ext;
  assign acc_add = acc + prod_ext;

  // Saturation to the history width (w after the feedback sum, or a scaled
  // history value during compensation) and of the output to the sample width.
  logic signed [AW-1:0]     hw_src;
  logic signed [HW-1:0]     hw_sat;
  logic signed [SW-1:0]     sw_sat;

  always_comb begin
    hw_src = (op == OP_A2) ? acc_sub : prod_ext;
    if ((&hw_src[AW-1:HW-1]) || !(|hw_src[AW-1:HW-1])) begin
      hw_sat = hw_src[HW-1:0];
    end else begin
      hw_sat = {hw_src[AW-1], {(HW-1){~hw_src[AW-1]}}};
    end
    if ((&acc_add[AW-1:SW-1]) || !(|acc_add[AW-1:SW-1])) begin
      sw_sat = acc_add[SW-1:0];
    end else begin
      sw_sat = {acc_add[AW-1], {(SW-1){~acc_add[AW-1]}}};
    end
  end

  // Compensation test and the ratio dividend, rounded to nearest by
  // adding half the divisor.
  logic [CW-1:0]            b0_mag;
  logic [CW-1:0]            old_mag;
  logic                     comp_hit;
  assign b0_mag   = coef[CO_B0][CW-1] ? CW'(-coef[CO_B0]) : CW'(coef[CO_B0]);
  assign old_mag  = old_b0[CW-1] ? CW'(-old_b0) : CW'(old_b0);
  assign comp_hit = compensate_enable &&
                    ((CW + 10)'(b0_mag) * (CW + 10)'(1000) > THRESHOLD);

  // Restoring division step, one quotient bit per cycle.
  logic [CW:0]              div_shift;
  logic                     div_ge;
  assign div_shift = {div_rem[CW-1:0], div_num[NW-1]};
  assign div_ge    = (div_shift >= {1'b0, div_mag});

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_start          <= '0;
      fb_start          <= '0;
      ff_step           <= '0;
      fb_step           <= '0;
      ramp_samples      <= '0;
      compensate_enable <= 1'b0;
      filter_enable     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FF_START: ff_start          <= cfg_data[3*FIELD_WIDTH-1:0];
        REG_FB_START: fb_start          <= cfg_data[2*FIELD_WIDTH-1:0];
        REG_FF_STEP:  ff_step           <= cfg_data[3*FIELD_WIDTH-1:0];
        REG_FB_STEP:  fb_step           <= cfg_data[2*FIELD_WIDTH-1:0];
        REG_RAMP:     ramp_samples      <= cfg_data[RAMP_WIDTH-1:0];
        REG_COMP:     compensate_enable <= cfg_data[0];
        REG_ENABLE:   filter_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer with its filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op         <= OP_A1;
      delay_near <= '0;
      delay_far  <= '0;
      ramp_left  <= '0;
      old_b0     <= '0;
      for (int k = 0; k < NUM_COEF; k++) begin
        coef[k] <= '0;
        inc[k]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            case (action)
              ACT_FILTER: begin
                if (filter_enable) begin
                  acc   <= AW'(sample_in);
                  op    <= OP_A1;
                  state <= ST_LOAD;
                end else begin
                  // A disabled filter passes the sample and keeps its state.
                  y_reg <= sample_in;
                  state <= ST_DONE;
                end
              end
              ACT_LOAD: begin
                for (int k = 0; k < NUM_COEF; k++) begin
                  coef[k] <= start_q[k];
                  inc[k]  <= step_q[k];
                end
                ramp_left <= ramp_samples;
              end
              ACT_CLEAR: begin
                delay_near <= '0;
                delay_far  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          mul_hi   <= '0;
          mul_lo   <= sel_mult;
          mul_cand <= sel_hist_mag;
          mul_neg  <= sel_neg;
          cnt      <= sel_ratio ? CNTW'(QW) : CNTW'(CW);
          state    <= ST_MUL;
        end
        ST_MUL: begin
          mul_hi <= mul_sum[HW:1];
          mul_lo <= {mul_sum[0], mul_lo[QW-1:1]};
          cnt    <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          case (op)
            OP_A1: begin
              acc   <= acc_sub;
              op    <= OP_A2;
              state <= ST_LOAD;
            end
            OP_A2: begin
              w_reg <= hw_sat;
              acc   <= '0;
              op    <= OP_B1;
              state <= ST_LOAD;
            end
            OP_B1, OP_B2: begin
              acc   <= acc_add;
              op    <= op + 1'b1;
              state <= ST_LOAD;
            end
            OP_B0: begin
              y_reg      <= sw_sat;
              delay_far  <= delay_near;
              delay_near <= w_reg;
              state      <= (ramp_left != '0) ? ST_RAMP : ST_DONE;
            end
            OP_R1: begin
              delay_near <= hw_sat;
              op         <= OP_R2;
              state      <= ST_LOAD;
            end
            default: begin
              delay_far <= hw_sat;
              state     <= ST_DONE;
            end
          endcase
        end
        ST_RAMP: begin
          old_b0    <= coef[CO_B0];
          ramp_left <= ramp_left - 1'b1;
          for (int k = 0; k < NUM_COEF; k++) begin
            coef[k] <= ramp_sat[k];
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (comp_hit) begin
            div_num <= {old_mag, {F{1'b0}}} + NW'(b0_mag >> 1);
            div_rem <= '0;
            div_mag <= b0_mag;
            cnt     <= CNTW'(NW);
            state   <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          div_rem <= div_ge ? (div_shift - {1'b0, div_mag}) : div_shift;
          div_num <= {div_num[NW-2:0], div_ge};
          cnt     <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            op    <= OP_R1;
            state <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: holds a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid   <= 1'b1;
      sample_out  <= y_reg;
      ramp_active <= (ramp_left != '0);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/bqcr_checker.sv
// ----------------------------------------------------------------------------
// Biquad coefficient ramp checker
// Port-level assertions on the handshakes of the filter, bound to its top.
// ----------------------------------------------------------------------------
module bqcr_assertions
  import bqcr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [ACTION_WIDTH-1:0]        action,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  // A held result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("held result changed or vanished");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A sample keeps the block busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_FILTER |=> in_stall)
    else $error("block free straight after a sample");

  // Load and clear leave the block free to take the next transaction.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACT_LOAD || action == ACT_CLEAR) |=> !in_stall)
    else $error("load or clear held the block");

endmodule

bind biquad_filter_coefficient_ramp_unit bqcr_assertions #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bqcr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .action     (action),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out)
);
